FILE: rtl/core/bse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_pkg
// Shared widths, opcodes and controller/datapath handshake types for the
// bitmap set engine.
// ----------------------------------------------------------------------------
package bse_pkg;

    // Store geometry
    localparam int MAX_BITS  = 1024;
    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WIDX_W    = $clog2(NUM_WORDS);

    // Field widths
    localparam int OP_W    = 3;
    localparam int LEN_W   = 11;
    localparam int HI_W    = LEN_W - BIT_W;
    localparam int POS_W   = 4;
    localparam int VAL_W   = 64;
    localparam int FOUND_W = 10;
    localparam int CNT_W   = 11;

    // Opcodes
    localparam logic [OP_W-1:0] OP_SET     = 3'd0;
    localparam logic [OP_W-1:0] OP_CLR     = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST    = 3'd2;
    localparam logic [OP_W-1:0] OP_OR      = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNT   = 3'd4;
    localparam logic [OP_W-1:0] OP_NEXT    = 3'd5;
    localparam logic [OP_W-1:0] OP_ALL_ON  = 3'd6;
    localparam logic [OP_W-1:0] OP_ALL_OFF = 3'd7;

    // Register map
    localparam logic REG_SET_LENGTH = 1'b0;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch a new item, clear working results
        logic exec;       // perform a non-scan operation
        logic walk_step;  // scan one stored word
        logic out_load;   // move working results into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic walk_op;    // current item scans the whole store
        logic walk_last;  // scan pointer is on the last word
        logic out_free;   // output register can take a result this cycle
    } status_t;

endpackage

FILE: rtl/core/bse_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_if
// Valid/ready channels carrying the bitmap set engine's items and results.
// ----------------------------------------------------------------------------
interface bse_in_if;
    logic                         valid;
    logic                         ready;
    logic [bse_pkg::OP_W-1:0]     opcode;
    logic [bse_pkg::LEN_W-1:0]    bit_index;
    logic [bse_pkg::POS_W-1:0]    word_position;
    logic [bse_pkg::VAL_W-1:0]    word_value;

    modport source (output valid, opcode, bit_index, word_position, word_value,
                    input ready);
    modport sink   (input valid, opcode, bit_index, word_position, word_value,
                    output ready);
endinterface

interface bse_out_if;
    logic                         valid;
    logic                         ready;
    logic                         bit_or_found;
    logic [bse_pkg::FOUND_W-1:0]  found_index;
    logic [bse_pkg::CNT_W-1:0]    set_count;
    logic                         index_error;

    modport source (output valid, bit_or_found, found_index, set_count, index_error,
                    input ready);
    modport sink   (input valid, bit_or_found, found_index, set_count, index_error,
                    output ready);
endinterface

FILE: rtl/core/bse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer: accept an item, run it or walk the store, hand off the result.
// ----------------------------------------------------------------------------
module bse_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output bse_pkg::cmd_t     cmd,
    input  bse_pkg::status_t  status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.walk_op)
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_WALK;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // A scan stays in WALK until the pointer reaches the last word
    a_walk_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) && !status.walk_last |=> (state_reg == S_WALK))
        else $error("scan left WALK before the last word");
`endif

endmodule

FILE: rtl/core/bse_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_dp
// Word store, bit/word operations, word-serial count and
// find-next scan, and the output register.
// ----------------------------------------------------------------------------
module bse_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  bse_pkg::cmd_t                   cmd,
    output bse_pkg::status_t                status,
    input  logic [bse_pkg::LEN_W-1:0]       set_length,
    input  logic [bse_pkg::OP_W-1:0]        opcode,
    input  logic [bse_pkg::LEN_W-1:0]       bit_index,
    input  logic [bse_pkg::POS_W-1:0]       word_position,
    input  logic [bse_pkg::VAL_W-1:0]       word_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            bit_or_found,
    output logic [bse_pkg::FOUND_W-1:0]     found_index,
    output logic [bse_pkg::CNT_W-1:0]       set_count,
    output logic                            index_error
);

    localparam int WB = bse_pkg::WORD_BITS;
    localparam int BW = bse_pkg::BIT_W;
    localparam int IW = bse_pkg::WIDX_W;
    localparam int LW = bse_pkg::LEN_W;
    localparam int HW = bse_pkg::HI_W;

    // Bits of word w that lie below lim
    function automatic logic [WB-1:0] below_mask(input logic [IW-1:0] w,
                                                 input logic [LW-1:0] lim);
        logic [HW-1:0] hi;
        logic [HW-1:0] wx;
        logic [WB-1:0] m;
        hi = lim[LW-1:BW];
        wx = HW'(w);
        if (wx < hi)
            m = '1;
        else if (wx == hi)
            m = (WB'(1) << lim[BW-1:0]) - WB'(1);
        else
            m = '0;
        return m;
    endfunction

    function automatic logic [BW:0] ones(input logic [WB-1:0] v);
        logic [BW:0] n;
        n = '0;
        for (int i = 0; i < WB; i++)
            n = n + (BW+1)'(v[i]);
        return n;
    endfunction

    function automatic logic [BW-1:0] lowest(input logic [WB-1:0] v);
        logic [BW-1:0] b;
        b = '0;
        for (int i = WB - 1; i >= 0; i--)
            if (v[i])
                b = BW'(i);
        return b;
    endfunction

    // Item registers
    logic [bse_pkg::OP_W-1:0]   op_reg;
    logic [LW-1:0]              idx_reg;
    logic [bse_pkg::POS_W-1:0]  pos_reg;
    logic [bse_pkg::VAL_W-1:0]  val_reg;

    // Store and scan
    logic [WB-1:0]  words_reg [bse_pkg::NUM_WORDS];
    logic [WB-1:0]  words_next [bse_pkg::NUM_WORDS];
    logic [IW-1:0]  ptr_reg;

    // Working results
    logic                          res_flag_reg;
    logic [bse_pkg::FOUND_W-1:0]   res_found_reg;
    logic [bse_pkg::CNT_W-1:0]     res_count_reg;
    logic                          res_err_reg;

    // Output register
    logic                          out_valid_reg;
    logic                          out_flag_reg;
    logic [bse_pkg::FOUND_W-1:0]   out_found_reg;
    logic [bse_pkg::CNT_W-1:0]     out_count_reg;
    logic                          out_err_reg;

    logic [LW-1:0]  len;
    logic           err;
    logic [LW-1:0]  start;
    logic [IW-1:0]  bit_word;
    logic [WB-1:0]  bit_mask;
    logic [IW-1:0]  rd_addr;
    logic [WB-1:0]  rd_word;
    logic [WB-1:0]  live_word;
    logic [WB-1:0]  hit;
    logic [WB-1:0]  from_mask;

    assign len = (set_length > LW'(bse_pkg::MAX_BITS)) ? LW'(bse_pkg::MAX_BITS)
                                                       : set_length;

    always_comb
    begin
        case (op_reg)
            bse_pkg::OP_SET, bse_pkg::OP_CLR, bse_pkg::OP_TEST:
                err = (idx_reg >= len);
            bse_pkg::OP_OR:
                err = (LW'({pos_reg, {BW{1'b0}}}) >= len);
            bse_pkg::OP_NEXT:
                err = (idx_reg > len);
            default:
                err = 1'b0;
        endcase
    end

    // Search begins just after the index; index equal to length wraps to bit 0
    assign start    = (idx_reg == len) ? '0 : idx_reg + LW'(1);

    always_comb
    begin
        if (start[LW-1:BW] > HW'(ptr_reg))
            from_mask = '0;
        else if (start[LW-1:BW] == HW'(ptr_reg))
            from_mask = ~((WB'(1) << start[BW-1:0]) - WB'(1));
        else
            from_mask = '1;
    end

    assign bit_word = idx_reg[BW+IW-1:BW];
    assign bit_mask = WB'(1) << idx_reg[BW-1:0];

    // Single read port on the store
    always_comb
    begin
        if (cmd.walk_step)
            rd_addr = ptr_reg;
        else if (op_reg == bse_pkg::OP_OR)
            rd_addr = IW'(pos_reg);
        else
            rd_addr = bit_word;
    end

    assign rd_word   = words_reg[rd_addr];
    assign live_word = rd_word & below_mask(rd_addr, len);
    assign hit       = live_word & from_mask;

    always_comb
    begin
        for (int w = 0; w < bse_pkg::NUM_WORDS; w++)
            words_next[w] = words_reg[w];
        if (cmd.exec)
        begin
            case (op_reg)
                bse_pkg::OP_SET:
                    if (!err)
                        words_next[bit_word] = rd_word | bit_mask;
                bse_pkg::OP_CLR:
                    if (!err)
                        words_next[bit_word] = rd_word & ~bit_mask;
                bse_pkg::OP_OR:
                    if (!err)
                        words_next[rd_addr] = rd_word |
                            (val_reg[WB-1:0] & below_mask(rd_addr, len));
                bse_pkg::OP_ALL_ON:
                    for (int w = 0; w < bse_pkg::NUM_WORDS; w++)
                        words_next[w] = below_mask(IW'(w), len);
                bse_pkg::OP_ALL_OFF:
                    for (int w = 0; w < bse_pkg::NUM_WORDS; w++)
                        words_next[w] = '0;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < bse_pkg::NUM_WORDS; w++)
                words_reg[w] <= '0;
        end
        else
        begin
            for (int w = 0; w < bse_pkg::NUM_WORDS; w++)
                words_reg[w] <= words_next[w];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            idx_reg <= bit_index;
            pos_reg <= word_position;
            val_reg <= word_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            res_flag_reg  <= 1'b0;
            res_found_reg <= '0;
            res_count_reg <= '0;
            res_err_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            ptr_reg       <= '0;
            res_flag_reg  <= 1'b0;
            res_found_reg <= '0;
            res_count_reg <= '0;
            res_err_reg   <= 1'b0;
        end
        else if (cmd.exec)
        begin
            res_err_reg  <= err;
            res_flag_reg <= (op_reg == bse_pkg::OP_TEST) && !err &&
                            rd_word[idx_reg[BW-1:0]];
        end
        else if (cmd.walk_step)
        begin
            ptr_reg     <= ptr_reg + IW'(1);
            res_err_reg <= err;
            if (op_reg == bse_pkg::OP_COUNT)
            begin
                res_count_reg <= res_count_reg + bse_pkg::CNT_W'(ones(live_word));
            end
            // Keep the first hit only
            if ((op_reg == bse_pkg::OP_NEXT) && !err && !res_flag_reg && (hit != '0))
            begin
                res_flag_reg  <= 1'b1;
                res_found_reg <= bse_pkg::FOUND_W'({ptr_reg, lowest(hit)});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_flag_reg  <= res_flag_reg;
            out_found_reg <= res_found_reg;
            out_count_reg <= res_count_reg;
            out_err_reg   <= res_err_reg;
        end
    end

    assign status.walk_op   = (op_reg == bse_pkg::OP_COUNT) || (op_reg == bse_pkg::OP_NEXT);
    assign status.walk_last = (ptr_reg == IW'(bse_pkg::NUM_WORDS - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign bit_or_found = out_flag_reg;
    assign found_index  = out_found_reg;
    assign set_count    = out_count_reg;
    assign index_error  = out_err_reg;

`ifndef SYNTH
    // A found bit always lies below the length when the result is handed off
    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && (op_reg == bse_pkg::OP_NEXT) && res_flag_reg |->
        (LW'(res_found_reg) < len))
        else $error("find-next reported a bit at or beyond the length");

    // An errored item reports nothing else
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_err_reg |-> !res_flag_reg && (res_count_reg == '0) && (res_found_reg == '0))
        else $error("error result carries other fields");

    // All-on never sets bits at or beyond the length in the last word
    a_all_on_masked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && (op_reg == bse_pkg::OP_ALL_ON) |=>
        ((words_reg[bse_pkg::NUM_WORDS-1] &
          ~below_mask(IW'(bse_pkg::NUM_WORDS - 1), len)) == '0))
        else $error("all-on set bits beyond the length");
`endif

endmodule

FILE: rtl/core/bitmap_set_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_set_engine_top
// Bitmap of up to 1024 bits with set/clear/test, word OR, population count,
// find-next, set-all and clear-all, behind valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one item per handshake: opcode, bit_index, word_position,
//          word_value. out_ch returns exactly one result item per input item,
//          in order: bit_or_found, found_index, set_count, index_error.
//   The APB port holds set_length at byte address 0 (writes take effect at
//   the access phase; pready is tied high). Write it only while idle.
// Timing:
//   Set, clear, test, OR, all-on and all-off: the item is accepted in IDLE,
//   runs in EXEC and is handed to the output register from FIN.
//   Count and find-next scan the 16-word store one word per cycle, from EXEC
//   through WALK to the last word, then hand off the result from FIN.
//   One item is in flight at a time; in_ch.ready is high only when idle.
// Reset:
//   rst_n clears the whole store to zero, sets set_length to 1024 and
//   empties the output register.
// Stalls:
//   A finished result waits in the output register while out_ch.ready is
//   low; the next item may still be accepted and runs until its own
//   result needs the output register, where it holds.
// ----------------------------------------------------------------------------
module bitmap_set_engine_top
(
    input  logic         clk,
    input  logic         rst_n,
    bse_in_if.sink       in_ch,
    bse_out_if.source    out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [bse_pkg::LEN_W-1:0]  set_length_reg;
    logic                       cfg_wr;
    bse_pkg::cmd_t              cmd;
    bse_pkg::status_t           status;
    logic                       in_ready;

    // Configuration: single register, index taken from the word address bit
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == bse_pkg::REG_SET_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_length_reg <= bse_pkg::LEN_W'(bse_pkg::MAX_BITS);
        end
        else if (cfg_wr)
        begin
            set_length_reg <= pwdata[bse_pkg::LEN_W-1:0];
        end
    end

    // Read back the stored value, zero for any other address
    assign prdata = (paddr[2] == bse_pkg::REG_SET_LENGTH)
                    ? 32'(set_length_reg) : 32'd0;

    bse_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    bse_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .set_length    (set_length_reg),
        .opcode        (in_ch.opcode),
        .bit_index     (in_ch.bit_index),
        .word_position (in_ch.word_position),
        .word_value    (in_ch.word_value),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .bit_or_found  (out_ch.bit_or_found),
        .found_index   (out_ch.found_index),
        .set_count     (out_ch.set_count),
        .index_error   (out_ch.index_error)
    );

    assign in_ch.ready = in_ready;

`ifndef SYNTH
    // One item at a time: acceptance drops ready for the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("second item accepted while one is in flight");
`endif

endmodule
